// ===== design/olpd_pkg.sv =====
// shared codes and field widths for the ordered list block
package olpd_pkg;

  localparam int FUNC_W  = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 7;
  localparam int LEN_W   = 7;
  localparam int STAT_W  = 2;
  localparam int DATA_W  = 40;

  localparam logic [FUNC_W-1:0] FN_INS_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INS_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_DEL_FRONT = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DEL_BACK  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DEL_POS   = 3'd4;
  localparam logic [FUNC_W-1:0] FN_READ      = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

endpackage

// ===== design/ordered_list_with_positional_delete.sv =====
// Bounded ordered list of signed values kept as a ring in a single memory.
// Input channel s_axis: one item names an operation in tuser (insert front,
// insert back, delete front, delete back, delete at a 1-based position, read
// out); tdata carries the value to insert and the position.
// Output channel m_axis: a readout of a non-empty list gives one item per element, front first,
// with tlast on the final one; every other operation gives one status item
// with tlast set, the status code in tuser and the new length in tdata.
// Inserts and plain deletes update the list on acceptance and then give their
// status item from the status state. Delete at position moves every element
// behind the gap through the memory, one a cycle, and then gives its status.
// A readout streams one element a cycle from the registered memory read while
// the receiver keeps accepting.
// The single slot adder and the one memory write port set this pace.
// s_axis_tready is high only while the sequencer is idle; a stalled receiver
// holds the output register and stops the readout stream at that point.
// Reset empties the list at once (front and length cleared); the element
// memory needs no clearing since only written entries are ever read.
module ordered_list_with_positional_delete
  import olpd_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,  // value [31:0], position [38:32], zero pad
  input  logic [FUNC_W-1:0] s_axis_tuser,  // func [2:0]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata,  // item_value [31:0], length [38:32], zero pad
  output logic              m_axis_tlast,
  output logic [STAT_W-1:0] m_axis_tuser   // status [1:0]
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = (CW > POS_W) ? CW : POS_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SHIFT  = 2'd1;
  localparam logic [1:0] S_READ   = 2'd2;
  localparam logic [1:0] S_STATUS = 2'd3;

  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] fr,
                                            input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(fr) + (CW+1)'(off);
    if (sum >= (CW+1)'(CAPACITY)) begin
      sum = sum - (CW+1)'(CAPACITY);
    end
    return sum[IW-1:0];
  endfunction

  logic [VALUE_W-1:0] mem [CAPACITY];

  logic [1:0]         state_q, state_d;
  logic [IW-1:0]      front_q, front_d;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      off_q, off_d;
  logic               first_q, first_d;
  logic               wv_q, wv_d;
  logic [IW-1:0]      a1_q, a1_d;
  logic [IW-1:0]      a2_q, a2_d;
  logic [STAT_W-1:0]  st_q, st_d;
  logic [VALUE_W-1:0] rdata_q;
  logic               rvalid_q, rvalid_d;
  logic               rlast_q, rlast_d;

  logic               m_valid_q, m_valid_d;
  logic [VALUE_W-1:0] m_value_q, m_value_d;
  logic               m_last_q, m_last_d;
  logic [STAT_W-1:0]  m_status_q, m_status_d;
  logic [CW-1:0]      m_len_q, m_len_d;

  logic [FUNC_W-1:0]  in_func;
  logic [VALUE_W-1:0] in_value;
  logic [POS_W-1:0]   in_pos;
  logic               accept;
  logic               out_free;
  logic               full;
  logic               empty;
  logic               rd_act;
  logic               load;
  logic [CW-1:0]      slot_off;
  logic [IW-1:0]      slot;
  logic               mem_we;
  logic [IW-1:0]      mem_wa;
  logic [VALUE_W-1:0] mem_wd;
  logic               mem_re;

  assign in_func  = s_axis_tuser;
  assign in_value = s_axis_tdata[VALUE_W-1:0];
  assign in_pos   = s_axis_tdata[VALUE_W+POS_W-1:VALUE_W];

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign full          = (count_q >= CW'(CAPACITY));
  assign empty         = (count_q == '0);
  assign rd_act        = (off_q < count_q);

  // offset select for the shared slot adder
  always_comb begin
    slot_off = off_q;
    if (state_q == S_IDLE) begin
      case (in_func)
        FN_INS_FRONT: slot_off = CW'(CAPACITY - 1);
        FN_INS_BACK:  slot_off = count_q;
        FN_DEL_FRONT: slot_off = CW'(1);
        default:      slot_off = '0;
      endcase
    end
  end

  assign slot = slot_of(front_q, slot_off);

  always_comb begin
    state_d    = state_q;
    front_d    = front_q;
    count_d    = count_q;
    off_d      = off_q;
    first_d    = first_q;
    wv_d       = wv_q;
    a1_d       = a1_q;
    a2_d       = a2_q;
    st_d       = st_q;
    rvalid_d   = rvalid_q;
    rlast_d    = rlast_q;
    m_valid_d  = m_valid_q;
    m_value_d  = m_value_q;
    m_last_d   = m_last_q;
    m_status_d = m_status_q;
    m_len_d    = m_len_q;
    mem_we     = 1'b0;
    mem_wa     = slot;
    mem_wd     = in_value;
    mem_re     = 1'b0;
    load       = 1'b0;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          st_d    = ST_OK;
          state_d = S_STATUS;
          case (in_func)
            FN_INS_FRONT: begin
              if (full) begin
                st_d = ST_FULL;
              end else begin
                mem_we  = 1'b1;
                front_d = slot;
                count_d = count_q + CW'(1);
              end
            end
            FN_INS_BACK: begin
              if (full) begin
                st_d = ST_FULL;
              end else begin
                mem_we  = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            FN_DEL_FRONT: begin
              if (empty) begin
                st_d = ST_EMPTY;
              end else begin
                front_d = slot;
                count_d = count_q - CW'(1);
              end
            end
            FN_DEL_BACK: begin
              if (empty) begin
                st_d = ST_EMPTY;
              end else begin
                count_d = count_q - CW'(1);
              end
            end
            FN_DEL_POS: begin
              if (empty) begin
                st_d = ST_EMPTY;
              end else if (in_pos == '0 || MW'(in_pos) > MW'(count_q)) begin
                st_d = ST_RANGE;
              end else begin
                off_d   = CW'(MW'(in_pos) - MW'(1));
                first_d = 1'b1;
                wv_d    = 1'b0;
                state_d = S_SHIFT;
              end
            end
            FN_READ: begin
              if (empty) begin
                st_d = ST_EMPTY;
              end else begin
                off_d    = '0;
                rvalid_d = 1'b0;
                state_d  = S_READ;
              end
            end
            default: begin
              st_d = ST_OK;
            end
          endcase
        end
      end

      S_SHIFT: begin
        // read offset j while writing offset j-2 with the data read from offset j-1
        mem_re  = rd_act;
        a1_d    = slot;
        a2_d    = a1_q;
        wv_d    = rd_act && !first_q;
        first_d = 1'b0;
        if (rd_act) begin
          off_d = off_q + CW'(1);
        end
        mem_we = wv_q;
        mem_wa = a2_q;
        mem_wd = rdata_q;
        if (!rd_act && !wv_q) begin
          count_d = count_q - CW'(1);
          st_d    = ST_OK;
          state_d = S_STATUS;
        end
      end

      S_READ: begin
        load = rvalid_q && out_free;
        if (load) begin
          m_valid_d  = 1'b1;
          m_value_d  = rdata_q;
          m_last_d   = rlast_q;
          m_status_d = ST_OK;
          m_len_d    = count_q;
          rvalid_d   = 1'b0;
        end
        if (rd_act && (!rvalid_q || load)) begin
          mem_re   = 1'b1;
          rvalid_d = 1'b1;
          rlast_d  = (off_q + CW'(1) == count_q);
          off_d    = off_q + CW'(1);
        end
        if (load && rlast_q) begin
          state_d = S_IDLE;
        end
      end

      S_STATUS: begin
        if (out_free) begin
          m_valid_d  = 1'b1;
          m_value_d  = '0;
          m_last_d   = 1'b1;
          m_status_d = st_q;
          m_len_d    = count_q;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // element memory, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= mem[slot];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      front_q   <= '0;
      count_q   <= '0;
      first_q   <= 1'b0;
      wv_q      <= 1'b0;
      rvalid_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      front_q   <= front_d;
      count_q   <= count_d;
      first_q   <= first_d;
      wv_q      <= wv_d;
      rvalid_q  <= rvalid_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q      <= off_d;
    a1_q       <= a1_d;
    a2_q       <= a2_d;
    st_q       <= st_d;
    rlast_q    <= rlast_d;
    m_value_q  <= m_value_d;
    m_last_q   <= m_last_d;
    m_status_q <= m_status_d;
    m_len_q    <= m_len_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(DATA_W - VALUE_W - LEN_W)'(0), LEN_W'(m_len_q), m_value_q};
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_status_q;

endmodule
